FILE: hw/rtl/cau_pkg.sv
`default_nettype none

package cau_pkg;

    localparam int CAU_FRAC_BITS   = 16;
    localparam int CAU_QUEUE_DEPTH = 4;
    localparam int CAU_DIV_STEPS   = 32;

    localparam logic [2:0] CMD_ADD = 3'd0;
    localparam logic [2:0] CMD_SUB = 3'd1;
    localparam logic [2:0] CMD_MUL = 3'd2;
    localparam logic [2:0] CMD_DIV = 3'd3;
    localparam logic [2:0] CMD_EQ  = 3'd4;
    localparam logic [2:0] CMD_NE  = 3'd5;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_DIV0 = 2'd1;
    localparam logic [1:0] ST_SAT  = 2'd2;

    typedef enum logic [2:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV,
        OP_EQ,
        OP_NE,
        OP_NONE
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [31:0] a_re;
        logic [31:0] a_im;
        logic [31:0] b_re;
        logic [31:0] b_im;
    } cau_item_t;

    typedef struct packed {
        logic [31:0] re;
        logic [31:0] im;
        logic        cmp_true;
        logic [1:0]  status;
    } cau_res_t;

    typedef struct packed {
        logic        sat;
        logic [31:0] val;
    } cau_fin_t;

    // apply sign to a magnitude and clamp to the signed 32-bit range
    function automatic cau_fin_t finish(input logic neg, input logic [64:0] mag);
        cau_fin_t f;
        f.sat = neg ? (mag > 65'h0_8000_0000) : (mag > 65'h0_7FFF_FFFF);
        if (f.sat)
        begin
            f.val = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        else
        begin
            f.val = neg ? (32'd0 - mag[31:0]) : mag[31:0];
        end
        return f;
    endfunction

    // clamp an exact 33-bit sum
    function automatic cau_fin_t sat33(input logic [32:0] s);
        cau_fin_t f;
        f.sat = s[32] ^ s[31];
        if (f.sat)
        begin
            f.val = s[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        else
        begin
            f.val = s[31:0];
        end
        return f;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/cau_if.sv
`default_nettype none

interface cau_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  cmd;
    logic [31:0] a_re;
    logic [31:0] a_im;
    logic [31:0] b_re;
    logic [31:0] b_im;

    modport source (output valid, cmd, a_re, a_im, b_re, b_im, input ready);
    modport sink   (input valid, cmd, a_re, a_im, b_re, b_im, output ready);
endinterface

interface cau_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] res_re;
    logic [31:0] res_im;
    logic        cmp_true;
    logic [1:0]  status;

    modport source (output valid, res_re, res_im, cmp_true, status, input ready);
    modport sink   (input valid, res_re, res_im, cmp_true, status, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/complex_arithmetic_unit.sv
// Complex ALU on signed Q16.16 operands (add, subtract, multiply, divide, equal, not equal).
// It takes one transaction per cycle and returns one result per transaction, in order.
// From acceptance to result valid a transaction passes the input queue, the stages of products,
// exact sums and sign split, a stage for product rounding and divider setup, 32 one-bit
// restoring divider steps and the output register. An accepted transaction is registered
// in the input queue before it enters the first stage, since the queue has no bypass.
// Every operation takes the full pipeline, so the order is kept.
// The whole pipeline holds while a result waits at the output; the input queue
// (QUEUE_DEPTH entries) keeps accepting until it is full.
`default_nettype none

module complex_arithmetic_unit #(
    parameter int FRAC_BITS   = cau_pkg::CAU_FRAC_BITS,
    parameter int QUEUE_DEPTH = cau_pkg::CAU_QUEUE_DEPTH
) (
    input  wire logic clk,
    input  wire logic rst_n,
    cau_req_if.sink   req,
    cau_rsp_if.source rsp
);
    import cau_pkg::*;

    cau_item_t head;
    logic      head_valid;
    logic      pop;

    cau_front #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .head      (head),
        .head_valid(head_valid),
        .pop       (pop)
    );

    cau_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .head_valid(head_valid),
        .pop       (pop),
        .rsp       (rsp)
    );

    // divide by zero returns zero parts
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && (rsp.status == ST_DIV0) |-> (rsp.res_re == '0) && (rsp.res_im == '0))
    else $error("divide by zero result not zero");

    // a true compare never carries a nonzero status
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.cmp_true |-> (rsp.status == ST_OK))
    else $error("compare result with error status");

    // a saturated result has a part at a limit
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && (rsp.status == ST_SAT) |->
            (rsp.res_re == 32'h7FFF_FFFF) || (rsp.res_re == 32'h8000_0000) ||
            (rsp.res_im == 32'h7FFF_FFFF) || (rsp.res_im == 32'h8000_0000))
    else $error("saturation flagged without a limit value");

endmodule

`default_nettype wire

FILE: hw/rtl/cau_front.sv
`default_nettype none

module cau_front #(
    parameter int QUEUE_DEPTH = cau_pkg::CAU_QUEUE_DEPTH
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    cau_req_if.sink            req,
    output cau_pkg::cau_item_t head,
    output logic               head_valid,
    input  wire logic          pop
);
    import cau_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(QUEUE_DEPTH - 1);
    localparam logic [CW-1:0] FULL = CW'(QUEUE_DEPTH);

    cau_item_t     mem_reg [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg, count_next;
    cau_item_t     item;
    logic          push, do_pop;

    always_comb
    begin
        item.a_re = req.a_re;
        item.a_im = req.a_im;
        item.b_re = req.b_re;
        item.b_im = req.b_im;
        case (req.cmd)
            CMD_ADD: item.op = OP_ADD;
            CMD_SUB: item.op = OP_SUB;
            CMD_MUL: item.op = OP_MUL;
            CMD_DIV: item.op = OP_DIV;
            CMD_EQ:  item.op = OP_EQ;
            CMD_NE:  item.op = OP_NE;
            default: item.op = OP_NONE;
        endcase
    end

    assign req.ready  = (count_reg != FULL);
    assign push       = req.valid && req.ready;
    assign head_valid = (count_reg != '0);
    assign do_pop     = pop && head_valid;
    assign head       = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= item;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/cau_div.sv
`default_nettype none

module cau_div #(
    parameter int FRAC_BITS = cau_pkg::CAU_FRAC_BITS
) (
    input  wire logic        clk,
    input  wire logic        adv,
    input  wire logic        in_neg,
    input  wire logic [63:0] in_mag,
    input  wire logic [63:0] in_den,
    output logic             out_neg,
    output logic             out_big,
    output logic [31:0]      out_q
);
    import cau_pkg::*;

    localparam int STEPS = CAU_DIV_STEPS;

    // scaled numerator split into its top 64 bits, which start the remainder, and the low bits fed in later
    logic [95:0] num_scaled;
    logic [63:0] num_top;

    logic [63:0] rem_reg [STEPS+1];
    logic [31:0] low_reg [STEPS+1];
    logic [31:0] q_reg   [STEPS+1];
    logic [63:0] den_reg [STEPS+1];
    logic        big_reg [STEPS+1];
    logic        neg_reg [STEPS+1];

    assign num_scaled = {32'd0, in_mag} << FRAC_BITS;
    assign num_top    = num_scaled[95:32];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rem_reg[0] <= num_top;
            low_reg[0] <= num_scaled[31:0];
            q_reg[0]   <= '0;
            den_reg[0] <= in_den;
            big_reg[0] <= (num_top >= in_den);
            neg_reg[0] <= in_neg;
        end
    end

    for (genvar k = 1; k <= STEPS; k++)
    begin : g_step
        logic [64:0] trial;
        logic [64:0] diff;
        logic        ge;

        assign trial = {rem_reg[k-1], low_reg[k-1][31]};
        assign diff  = trial - {1'b0, den_reg[k-1]};
        assign ge    = (trial >= {1'b0, den_reg[k-1]});

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[k] <= ge ? diff[63:0] : trial[63:0];
                low_reg[k] <= {low_reg[k-1][30:0], 1'b0};
                q_reg[k]   <= {q_reg[k-1][30:0], ge};
                den_reg[k] <= den_reg[k-1];
                big_reg[k] <= big_reg[k-1];
                neg_reg[k] <= neg_reg[k-1];
            end
        end
    end

    assign out_neg = neg_reg[STEPS];
    assign out_big = big_reg[STEPS];
    assign out_q   = q_reg[STEPS];

endmodule

`default_nettype wire

FILE: hw/rtl/cau_back.sv
`default_nettype none

module cau_back #(
    parameter int FRAC_BITS = cau_pkg::CAU_FRAC_BITS
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  cau_pkg::cau_item_t head,
    input  wire logic          head_valid,
    output logic               pop,
    cau_rsp_if.source          rsp
);
    import cau_pkg::*;

    localparam int STEPS = CAU_DIV_STEPS;
    localparam logic [64:0] HALF = (65'd1 << FRAC_BITS) >> 1;

    logic adv;

    // stage 1: products and the simple operations
    logic              v1_reg;
    op_t               op1_reg;
    cau_res_t          simple1_reg;
    logic signed [63:0] p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg, p_b1_reg, p_b2_reg;
    cau_res_t          simple_next;
    logic [32:0]       add_re, add_im, sub_re, sub_im;
    cau_fin_t          f_re, f_im;

    // stage 2: exact sums
    logic              v2_reg;
    op_t               op2_reg;
    cau_res_t          simple2_reg;
    logic signed [64:0] mre_reg, mim_reg, dre_reg, dim_reg;
    logic [63:0]       den2_reg;

    // stage 3: sign and magnitude
    logic              v3_reg;
    op_t               op3_reg;
    cau_res_t          simple3_reg;
    logic              mre_neg_reg, mim_neg_reg, dre_neg_reg, dim_neg_reg;
    logic [63:0]       mre_mag_reg, mim_mag_reg, dre_mag_reg, dim_mag_reg;
    logic [63:0]       den3_reg;

    // stage 4 and the divider steps
    logic [64:0]       rnd_re, rnd_im;
    cau_fin_t          mf_re, mf_im;
    cau_res_t          tag_next;
    logic              vd_reg   [STEPS+1];
    cau_res_t          tag_reg  [STEPS+1];
    logic              useq_reg [STEPS+1];

    logic              q_re_neg, q_re_big, q_im_neg, q_im_big;
    logic [31:0]       q_re, q_im;
    cau_fin_t          qf_re, qf_im;
    cau_res_t          final_res;

    logic              out_valid_reg;
    cau_res_t          out_reg;

    assign adv = !out_valid_reg || rsp.ready;
    assign pop = adv && head_valid;

    always_comb
    begin
        add_re = {head.a_re[31], head.a_re} + {head.b_re[31], head.b_re};
        add_im = {head.a_im[31], head.a_im} + {head.b_im[31], head.b_im};
        sub_re = {head.a_re[31], head.a_re} - {head.b_re[31], head.b_re};
        sub_im = {head.a_im[31], head.a_im} - {head.b_im[31], head.b_im};
        f_re = sat33(add_re);
        f_im = sat33(add_im);
        if (head.op == OP_SUB)
        begin
            f_re = sat33(sub_re);
            f_im = sat33(sub_im);
        end
        simple_next = '0;
        case (head.op)
            OP_ADD, OP_SUB:
            begin
                simple_next.re     = f_re.val;
                simple_next.im     = f_im.val;
                simple_next.status = (f_re.sat || f_im.sat) ? ST_SAT : ST_OK;
            end
            OP_EQ:
            begin
                simple_next.cmp_true = (head.a_re == head.b_re) && (head.a_im == head.b_im);
            end
            OP_NE:
            begin
                simple_next.cmp_true = (head.a_re != head.b_re) || (head.a_im != head.b_im);
            end
            default:
            begin
                simple_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            op1_reg     <= head.op;
            simple1_reg <= simple_next;
            p_rr_reg    <= $signed(head.a_re) * $signed(head.b_re);
            p_ii_reg    <= $signed(head.a_im) * $signed(head.b_im);
            p_ri_reg    <= $signed(head.a_re) * $signed(head.b_im);
            p_ir_reg    <= $signed(head.a_im) * $signed(head.b_re);
            p_b1_reg    <= $signed(head.b_re) * $signed(head.b_re);
            p_b2_reg    <= $signed(head.b_im) * $signed(head.b_im);

            op2_reg     <= op1_reg;
            simple2_reg <= simple1_reg;
            mre_reg     <= {p_rr_reg[63], p_rr_reg} - {p_ii_reg[63], p_ii_reg};
            mim_reg     <= {p_ri_reg[63], p_ri_reg} + {p_ir_reg[63], p_ir_reg};
            dre_reg     <= {p_rr_reg[63], p_rr_reg} + {p_ii_reg[63], p_ii_reg};
            dim_reg     <= {p_ir_reg[63], p_ir_reg} - {p_ri_reg[63], p_ri_reg};
            den2_reg    <= $unsigned(p_b1_reg) + $unsigned(p_b2_reg);

            op3_reg     <= op2_reg;
            simple3_reg <= simple2_reg;
            mre_neg_reg <= mre_reg[64];
            mim_neg_reg <= mim_reg[64];
            dre_neg_reg <= dre_reg[64];
            dim_neg_reg <= dim_reg[64];
            mre_mag_reg <= mre_reg[64] ? 64'(65'd0 - mre_reg) : mre_reg[63:0];
            mim_mag_reg <= mim_reg[64] ? 64'(65'd0 - mim_reg) : mim_reg[63:0];
            dre_mag_reg <= dre_reg[64] ? 64'(65'd0 - dre_reg) : dre_reg[63:0];
            dim_mag_reg <= dim_reg[64] ? 64'(65'd0 - dim_reg) : dim_reg[63:0];
            den3_reg    <= den2_reg;
        end
    end

    // product rounding: nearest, ties away from zero, on the magnitude
    always_comb
    begin
        rnd_re = ({1'b0, mre_mag_reg} + HALF) >> FRAC_BITS;
        rnd_im = ({1'b0, mim_mag_reg} + HALF) >> FRAC_BITS;
        mf_re  = finish(mre_neg_reg, rnd_re);
        mf_im  = finish(mim_neg_reg, rnd_im);
        tag_next = simple3_reg;
        case (op3_reg)
            OP_MUL:
            begin
                tag_next.re       = mf_re.val;
                tag_next.im       = mf_im.val;
                tag_next.cmp_true = 1'b0;
                tag_next.status   = (mf_re.sat || mf_im.sat) ? ST_SAT : ST_OK;
            end
            OP_DIV:
            begin
                tag_next        = '0;
                tag_next.status = ST_DIV0;
            end
            default:
            begin
                tag_next = simple3_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tag_reg[0]  <= tag_next;
            useq_reg[0] <= (op3_reg == OP_DIV) && (den3_reg != '0);
            for (int k = 1; k <= STEPS; k++)
            begin
                tag_reg[k]  <= tag_reg[k-1];
                useq_reg[k] <= useq_reg[k-1];
            end
        end
    end

    cau_div #(.FRAC_BITS(FRAC_BITS)) u_div_re (
        .clk    (clk),
        .adv    (adv),
        .in_neg (dre_neg_reg),
        .in_mag (dre_mag_reg),
        .in_den (den3_reg),
        .out_neg(q_re_neg),
        .out_big(q_re_big),
        .out_q  (q_re)
    );

    cau_div #(.FRAC_BITS(FRAC_BITS)) u_div_im (
        .clk    (clk),
        .adv    (adv),
        .in_neg (dim_neg_reg),
        .in_mag (dim_mag_reg),
        .in_den (den3_reg),
        .out_neg(q_im_neg),
        .out_big(q_im_big),
        .out_q  (q_im)
    );

    always_comb
    begin
        qf_re = finish(q_re_neg, q_re_big ? 65'h1_0000_0000 : {33'd0, q_re});
        qf_im = finish(q_im_neg, q_im_big ? 65'h1_0000_0000 : {33'd0, q_im});
        if (useq_reg[STEPS])
        begin
            final_res.re       = qf_re.val;
            final_res.im       = qf_im.val;
            final_res.cmp_true = 1'b0;
            final_res.status   = (qf_re.sat || qf_im.sat) ? ST_SAT : ST_OK;
        end
        else
        begin
            final_res = tag_reg[STEPS];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k <= STEPS; k++)
            begin
                vd_reg[k] <= 1'b0;
            end
        end
        else if (adv)
        begin
            v1_reg        <= head_valid;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            vd_reg[0]     <= v3_reg;
            for (int k = 1; k <= STEPS; k++)
            begin
                vd_reg[k] <= vd_reg[k-1];
            end
            out_valid_reg <= vd_reg[STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_reg <= final_res;
        end
    end

    assign rsp.valid    = out_valid_reg;
    assign rsp.res_re   = out_reg.re;
    assign rsp.res_im   = out_reg.im;
    assign rsp.cmp_true = out_reg.cmp_true;
    assign rsp.status   = out_reg.status;

endmodule

`default_nettype wire
